@@ rtl/hrp_pkg.sv @@
package hrp_pkg;

    localparam int MAX_NAL_BYTES_DEF = 65535;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SSRC         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 2'd3;

    localparam logic [6:0]  PAYLOAD_TYPE_RST = 7'd96;
    localparam logic [11:0] MAX_PAYLOAD_RST  = 12'd1200;

    // RTP / FU-A bytes
    localparam logic [7:0] RTP_BYTE0   = 8'h80;
    localparam logic [7:0] NRI_MASK    = 8'hE0;
    localparam logic [7:0] TYPE_MASK   = 8'h1F;
    localparam logic [7:0] FU_A_TYPE   = 8'd28;
    localparam logic [7:0] FU_START    = 8'h80;
    localparam logic [7:0] FU_END      = 8'h40;

    // header that goes in front of a payload byte
    localparam logic [1:0] HDR_NONE   = 2'd0;
    localparam logic [1:0] HDR_SINGLE = 2'd1;
    localparam logic [1:0] HDR_FRAG   = 2'd2;

    localparam logic [3:0] HDR_LEN_RTP = 4'd12;
    localparam logic [3:0] HDR_LEN_FU  = 4'd14;

    typedef struct packed {
        logic [7:0]  nal_byte;
        logic [15:0] nal_length;
        logic        last_byte;
        logic [31:0] frame_time;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
        logic       run_last;
    } out_t;

    typedef struct packed {
        logic [6:0]  payload_type;
        logic [31:0] stream_source_id;
        logic [11:0] max_payload;
        logic        enable;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  hdr_kind;
        logic        marker;
        logic [15:0] seq;
        logic [31:0] stamp;
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
        logic [7:0]  data;
        logic        pend;
    } job_t;

endpackage

@@ rtl/h264_rtp_packetizer.sv @@
// H.264 to RTP packetizer. NAL unit bytes go in one per beat and RTP packet
// bytes come out one per beat. A unit that fits max_payload leaves as one
// packet with the marker set; a longer one is split into FU-A fragments of
// at most max_payload-2 bytes. The input side classifies each byte and
// queues a job; the output side expands a job into the 12-byte RTP header
// (plus FU indicator and FU header when fragmenting) and the payload byte.
// Payload bytes flow at one per cycle while the receiver pops; a packet
// start puts 12 (single) or 14 (fragment) header bytes before its payload
// byte, the header byte sequencer being the limit, and meanwhile the input
// keeps taking bytes until the QUEUE_DEPTH job queue fills. A single output
// register holds the oldest byte; each job passes from the job queue into it.
// Configuration writes are always ready and are meant to be made while the
// block is idle.
module h264_rtp_packetizer #(
    parameter int MAX_NAL_BYTES = hrp_pkg::MAX_NAL_BYTES_DEF,
    parameter int QUEUE_DEPTH   = hrp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  hrp_pkg::in_t                    item,
    output logic                            empty,
    input  logic                            pop,
    output hrp_pkg::out_t                   result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hrp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hrp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    hrp_pkg::cfg_t cfg_reg;
    logic          accept;
    logic          job_push;
    hrp_pkg::job_t job;
    hrp_pkg::job_t head;
    logic          head_valid;
    logic          deq;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.payload_type     <= hrp_pkg::PAYLOAD_TYPE_RST;
            cfg_reg.stream_source_id <= '0;
            cfg_reg.max_payload      <= hrp_pkg::MAX_PAYLOAD_RST;
            cfg_reg.enable           <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hrp_pkg::REG_PAYLOAD_TYPE: cfg_reg.payload_type     <= cfg_data[6:0];
                hrp_pkg::REG_SSRC:         cfg_reg.stream_source_id <= cfg_data;
                hrp_pkg::REG_MAX_PAYLOAD:  cfg_reg.max_payload      <= cfg_data[11:0];
                hrp_pkg::REG_ENABLE:       cfg_reg.enable           <= cfg_data[0];
                default: ;
            endcase
        end
    end

    hrp_front #(
        .MAX_NAL_BYTES(MAX_NAL_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cfg      (cfg_reg),
        .job_push (job_push),
        .job      (job)
    );

    hrp_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job),
        .full  (full),
        .pop   (deq),
        .rdata (head),
        .avail (head_valid)
    );

    hrp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .head_valid (head_valid),
        .deq        (deq),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

    // a byte ending a packet is always the payload byte, hence last of its run
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.packet_end) |-> result.run_last)
        else $error("packet_end without run_last");

    // retiring a job leaves its payload byte in the output register
    a_deq_loads_payload: assert property (@(posedge clk) disable iff (!rst_n)
        deq |=> (!empty && result.run_last))
        else $error("job retired without its payload beat");

    // a disabled channel queues nothing
    a_disabled_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_reg.enable) |-> !job_push)
        else $error("job queued while disabled");

endmodule

@@ rtl/hrp_front.sv @@
module hrp_front #(
    parameter int MAX_NAL_BYTES = hrp_pkg::MAX_NAL_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  hrp_pkg::in_t  item,
    input  hrp_pkg::cfg_t cfg,
    output logic          job_push,
    output hrp_pkg::job_t job
);

    localparam int MW = $clog2(MAX_NAL_BYTES + 1);
    localparam int CW = (MW > 17) ? MW : 17;

    logic [15:0] pos_reg, pos_next;
    logic [11:0] cf_reg, cf_next;
    logic        frag_reg, frag_next;
    logic [7:0]  saved_reg, saved_next;
    logic [31:0] time_reg, time_next;
    logic [15:0] seq_reg, seq_next;

    logic [16:0] pos_inc;
    logic        end_len;
    logic        end_max;

    assign pos_inc = {1'b0, pos_reg} + 17'd1;
    assign end_len = pos_inc >= {1'b0, item.nal_length};
    assign end_max = CW'(pos_inc) >= CW'(MAX_NAL_BYTES);

    always_comb
    begin
        logic        first;
        logic        frag;
        logic [7:0]  hdr;
        logic [31:0] stamp;
        logic [11:0] cf;
        logic [11:0] cf1;
        logic [11:0] limit;
        logic [15:0] rem;
        logic        is_last;
        logic        end_unit;
        logic        pend;

        pos_next   = pos_reg;
        cf_next    = cf_reg;
        frag_next  = frag_reg;
        saved_next = saved_reg;
        time_next  = time_reg;
        seq_next   = seq_reg;
        job_push   = 1'b0;
        job        = '0;

        first    = pos_reg == 16'd0;
        frag     = first ? (item.nal_length > {4'b0, cfg.max_payload}) : frag_reg;
        hdr      = first ? item.nal_byte : saved_reg;
        stamp    = first ? item.frame_time : time_reg;
        cf       = first ? 12'd0 : cf_reg;
        cf1      = cf + 12'd1;
        limit    = (cfg.max_payload >= 12'd3) ? cfg.max_payload - 12'd2 : 12'd1;
        rem      = (item.nal_length > pos_reg) ? item.nal_length - pos_reg : 16'd1;
        is_last  = rem <= {4'b0, limit};
        end_unit = item.last_byte | end_len | end_max;
        pend     = 1'b0;

        if (accept && cfg.enable)
        begin
            if (first)
            begin
                saved_next = item.nal_byte;
                time_next  = item.frame_time;
            end
            job.seq   = seq_reg;
            job.stamp = stamp;
            job.data  = item.nal_byte;
            cf_next   = cf;

            if (!frag)
            begin
                // single packet: running into the payload limit closes the unit
                if (cf1 >= cfg.max_payload)
                    end_unit = 1'b1;
                job_push     = 1'b1;
                job.hdr_kind = first ? hrp_pkg::HDR_SINGLE : hrp_pkg::HDR_NONE;
                job.marker   = 1'b1;
                pend         = end_unit;
                cf_next      = cf1;
            end
            else if (!first)
            begin
                if (cf == 12'd0)
                begin
                    job.hdr_kind = hrp_pkg::HDR_FRAG;
                    job.marker   = is_last;
                    job.fu_ind   = (hdr & hrp_pkg::NRI_MASK) | hrp_pkg::FU_A_TYPE;
                    job.fu_hdr   = (hdr & hrp_pkg::TYPE_MASK)
                                 | ((pos_reg == 16'd1) ? hrp_pkg::FU_START : 8'h00)
                                 | (is_last ? hrp_pkg::FU_END : 8'h00);
                end
                else
                begin
                    job.hdr_kind = hrp_pkg::HDR_NONE;
                end
                job_push = 1'b1;
                pend     = end_unit | (cf1 >= limit);
                cf_next  = pend ? 12'd0 : cf1;
            end
            // fragmenting NAL header byte is held back: no beat

            job.pend  = pend;
            frag_next = frag;
            if (job_push && (job.hdr_kind != hrp_pkg::HDR_NONE))
                seq_next = seq_reg + 16'd1;

            if (end_unit)
            begin
                pos_next  = 16'd0;
                cf_next   = 12'd0;
                frag_next = 1'b0;
            end
            else
            begin
                pos_next = pos_inc[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            cf_reg    <= '0;
            frag_reg  <= 1'b0;
            saved_reg <= '0;
            time_reg  <= '0;
            seq_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            cf_reg    <= cf_next;
            frag_reg  <= frag_next;
            saved_reg <= saved_next;
            time_reg  <= time_next;
            seq_reg   <= seq_next;
        end
    end

endmodule

@@ rtl/hrp_fifo.sv @@
module hrp_fifo #(
    parameter int DEPTH = hrp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hrp_pkg::job_t wdata,
    output logic          full,
    input  logic          pop,
    output hrp_pkg::job_t rdata,
    output logic          avail
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    hrp_pkg::job_t  mem [DEPTH];
    logic [AW-1:0]  wr_reg, wr_next;
    logic [AW-1:0]  rd_reg, rd_next;
    logic [NW-1:0]  cnt_reg, cnt_next;
    logic           do_push;
    logic           do_pop;

    assign full    = cnt_reg == NW'(DEPTH);
    assign avail   = cnt_reg != '0;
    assign do_push = push && !full;
    assign do_pop  = pop && avail;
    assign rdata   = mem[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
        if (do_pop)
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + NW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - NW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ rtl/hrp_back.sv @@
module hrp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  hrp_pkg::cfg_t cfg,
    input  hrp_pkg::job_t head,
    input  logic          head_valid,
    output logic          deq,
    output logic          empty,
    input  logic          pop,
    output hrp_pkg::out_t result
);

    logic [3:0]    idx_reg;
    logic          out_valid_reg;
    hrp_pkg::out_t out_reg;
    logic          load;
    logic [3:0]    hlen;
    logic          at_payload;
    logic [7:0]    sel_byte;

    assign load       = !out_valid_reg || pop;
    assign at_payload = idx_reg == hlen;
    assign deq        = load && head_valid && at_payload;
    assign empty      = !out_valid_reg;
    assign result     = out_reg;

    always_comb
    begin
        case (head.hdr_kind)
            hrp_pkg::HDR_SINGLE: hlen = hrp_pkg::HDR_LEN_RTP;
            hrp_pkg::HDR_FRAG:   hlen = hrp_pkg::HDR_LEN_FU;
            default:             hlen = 4'd0;
        endcase
    end

    always_comb
    begin
        if (at_payload)
        begin
            sel_byte = head.data;
        end
        else
        begin
            case (idx_reg)
                4'd0:    sel_byte = hrp_pkg::RTP_BYTE0;
                4'd1:    sel_byte = {head.marker, cfg.payload_type};
                4'd2:    sel_byte = head.seq[15:8];
                4'd3:    sel_byte = head.seq[7:0];
                4'd4:    sel_byte = head.stamp[31:24];
                4'd5:    sel_byte = head.stamp[23:16];
                4'd6:    sel_byte = head.stamp[15:8];
                4'd7:    sel_byte = head.stamp[7:0];
                4'd8:    sel_byte = cfg.stream_source_id[31:24];
                4'd9:    sel_byte = cfg.stream_source_id[23:16];
                4'd10:   sel_byte = cfg.stream_source_id[15:8];
                4'd11:   sel_byte = cfg.stream_source_id[7:0];
                4'd12:   sel_byte = head.fu_ind;
                4'd13:   sel_byte = head.fu_hdr;
                default: sel_byte = 8'h00;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= head_valid;
            if (head_valid)
                idx_reg <= at_payload ? 4'd0 : idx_reg + 4'd1;
        end
    end

    // the payload byte of a job is always the last beat of its input byte
    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            out_reg.out_byte   <= sel_byte;
            out_reg.packet_end <= at_payload & head.pend;
            out_reg.run_last   <= at_payload;
        end
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import hrp_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 12;

    // Expected RTP byte stream, built up from the NAL bytes accepted so far.
    class rtp_byte_scoreboard;
        logic [6:0]  pt;
        logic [31:0] ssrc;
        logic [11:0] max_pl;
        logic        en;

        logic [15:0] seq;
        logic [7:0]  nal_hdr;
        logic [15:0] pos;
        logic [11:0] fill;
        logic        frag;
        logic [31:0] stamp;

        out_t due[$];
        out_t run[$];
        int   errors;

        function new();
            pt      = PAYLOAD_TYPE_RST;
            ssrc    = '0;
            max_pl  = MAX_PAYLOAD_RST;
            en      = 1'b0;
            seq     = '0;
            nal_hdr = '0;
            pos     = '0;
            fill    = '0;
            frag    = 1'b0;
            stamp   = '0;
            errors  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_PAYLOAD_TYPE: pt = d[6:0];
                REG_SSRC:         ssrc = d;
                REG_MAX_PAYLOAD:  max_pl = d[11:0];
                REG_ENABLE:       en = d[0];
                default:          ;
            endcase
        endfunction

        function void emit(logic [7:0] b, logic pend);
            out_t r;
            r.out_byte   = b;
            r.packet_end = pend;
            r.run_last   = 1'b0;
            run.insert(run.size(), r);
        endfunction

        function void emit_header(logic marker);
            emit(RTP_BYTE0, 1'b0);
            emit({marker, pt}, 1'b0);
            emit(seq[15:8], 1'b0);
            emit(seq[7:0], 1'b0);
            seq = seq + 16'd1;
            emit(stamp[31:24], 1'b0);
            emit(stamp[23:16], 1'b0);
            emit(stamp[15:8], 1'b0);
            emit(stamp[7:0], 1'b0);
            emit(ssrc[31:24], 1'b0);
            emit(ssrc[23:16], 1'b0);
            emit(ssrc[15:8], 1'b0);
            emit(ssrc[7:0], 1'b0);
        endfunction

        function void take_nal_byte(in_t it);
            logic        last_unit;
            logic        is_last;
            logic        pend;
            int unsigned limit;
            int unsigned rem;
            logic [7:0]  fuh;
            out_t        r;

            if (!en)
                return;
            run.delete();
            last_unit = it.last_byte || (int'(pos) + 1 >= int'(it.nal_length)) ||
                        (int'(pos) + 1 >= MAX_NAL_BYTES_DEF);
            limit = (max_pl >= 3) ? int'(max_pl) - 2 : 1;

            if (pos == 0)
            begin
                stamp   = it.frame_time;
                nal_hdr = it.nal_byte;
                frag    = it.nal_length > max_pl;
                fill    = '0;
            end

            if (!frag)
            begin
                if (pos == 0)
                    emit_header(1'b1);
                fill = fill + 12'd1;
                // a single packet that runs into the limit closes the unit
                if (fill >= max_pl)
                    last_unit = 1'b1;
                emit(it.nal_byte, last_unit);
            end
            else if (pos != 0)
            begin
                if (fill == 0)
                begin
                    rem     = (it.nal_length > pos) ? int'(it.nal_length) - int'(pos) : 1;
                    is_last = rem <= limit;
                    fuh     = nal_hdr & TYPE_MASK;
                    if (pos == 1)
                        fuh = fuh | FU_START;
                    if (is_last)
                        fuh = fuh | FU_END;
                    emit_header(is_last);
                    emit((nal_hdr & NRI_MASK) | FU_A_TYPE, 1'b0);
                    emit(fuh, 1'b0);
                end
                fill = fill + 12'd1;
                pend = last_unit || (fill >= limit);
                emit(it.nal_byte, pend);
                if (pend)
                    fill = '0;
            end
            // in fragment mode the NAL header byte itself is held back

            if (last_unit)
            begin
                pos  = '0;
                fill = '0;
                frag = 1'b0;
            end
            else
            begin
                pos = pos + 16'd1;
            end

            if (run.size() > 0)
            begin
                r = run.pop_back();
                r.run_last = 1'b1;
                run.insert(run.size(), r);
            end
            foreach (run[k])
                due.insert(due.size(), run[k]);
        endfunction

        function void check_rtp_byte(out_t r);
            out_t e;
            if (due.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got %02h/%0b/%0b",
                         $time, r.out_byte, r.packet_end, r.run_last);
                errors++;
                return;
            end
            e = due.pop_front();
            if (r.out_byte !== e.out_byte)
            begin
                $display("%0t: out_byte expected %02h got %02h", $time, e.out_byte, r.out_byte);
                errors++;
            end
            if (r.packet_end !== e.packet_end)
            begin
                $display("%0t: packet_end expected %0b got %0b",
                         $time, e.packet_end, r.packet_end);
                errors++;
            end
            if (r.run_last !== e.run_last)
            begin
                $display("%0t: run_last expected %0b got %0b", $time, e.run_last, r.run_last);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    in_t                   item;
    logic                  empty;
    logic                  pop;
    out_t                  result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rtp_byte_scoreboard sb = new();

    logic src_gaps = 1'b1;
    logic rcv_gaps = 1'b1;
    logic hold_off = 1'b0;
    int   quiet    = 0;

    h264_rtp_packetizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.take_nal_byte(item);
            if (pop && !empty)
                sb.check_rtp_byte(result);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiving side: random stalls, plus one long hold-off to back the block up
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_off)
            begin
                pop = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
            end
            else if (rcv_gaps && $urandom_range(0, 4) == 0)
            begin
                pop = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            else
            begin
                pop = 1'b1;
                @(negedge clk);
            end
        end
    end

    task automatic send_beat(input in_t beat);
        if (src_gaps && $urandom_range(0, 5) == 0)
        begin
            push = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        push = 1'b1;
        item = beat;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_unit(input logic [7:0] hdr, input int n_bytes,
                             input logic [15:0] len_first, input logic [15:0] len_rest,
                             input int flag_at, input logic [31:0] stamp);
        in_t beat;
        for (int k = 0; k < n_bytes; k++)
        begin
            beat.nal_byte   = (k == 0) ? hdr : 8'($urandom);
            beat.nal_length = (k == 0) ? len_first : len_rest;
            beat.last_byte  = (k == flag_at);
            // only the first byte's time is latched
            beat.frame_time = (k == 0) ? stamp : $urandom;
            send_beat(beat);
        end
    endtask

    // returns once every expected beat is out and the block has had time to go quiet
    task automatic settle();
        push = 1'b0;
        while (sb.due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic [6:0] pt, input logic [31:0] ssrc,
                              input logic [11:0] max_pl, input logic en);
        write_reg(REG_PAYLOAD_TYPE, 32'(pt));
        write_reg(REG_SSRC, ssrc);
        write_reg(REG_MAX_PAYLOAD, 32'(max_pl));
        write_reg(REG_ENABLE, 32'(en));
    endtask

    task automatic random_units(input int n_items);
        int sent;
        int n;
        int kind;
        logic [15:0] len;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 9);
            n    = $urandom_range(1, 12);
            if (kind < 7)
            begin
                len = 16'(n);
                send_unit(8'($urandom), n, len, len,
                          ($urandom_range(0, 1) == 1) ? n - 1 : -1, $urandom);
            end
            else if (kind < 9)
            begin
                // wide declared length, cut short by the last-byte flag
                len = 16'($urandom);
                send_unit(8'($urandom), n, len, len, n - 1, $urandom);
            end
            else
            begin
                len = 16'($urandom_range(0, 15));
                send_unit(8'($urandom), n, len, 16'($urandom_range(0, 15)),
                          ($urandom_range(0, 1) == 1) ? $urandom_range(0, n - 1) : -1,
                          $urandom);
            end
            sent += n;
        end
    endtask

    function automatic logic [11:0] pick_max_payload();
        case ($urandom_range(0, 3))
            0:       return 12'd1;
            1:       return 12'd2;
            default: return 12'($urandom_range(3, 12));
        endcase
    endfunction

    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_config(7'd127, 32'hFFFF_FFFF, 12'd4, 1'b1);
        send_unit(8'hFF, 1, 16'd1, 16'd1, 0, 32'hFFFF_FFFF);
        send_unit(8'h00, 3, 16'd3, 16'd3, 2, 32'h0000_0000);
        send_unit(8'h65, 7, 16'd7, 16'd7, 6, 32'h1234_5678);
        // fragmented unit that stops before its announced length
        send_unit(8'h7C, 5, 16'd20, 16'd20, 4, 32'h8765_4321);
        // fragmented unit made of the NAL header alone
        send_unit(8'h41, 1, 16'd9, 16'd9, 0, 32'hA5A5_5A5A);
        // single packet that overruns the payload limit
        send_unit(8'h21, 4, 16'd2, 16'd100, -1, 32'h0F0F_F0F0);
        // zero length: each byte is a unit of its own
        send_unit(8'h5A, 2, 16'd0, 16'd0, -1, 32'h5555_AAAA);
        settle();

        write_reg(REG_ENABLE, 32'd0);
        send_unit(8'h67, 3, 16'd3, 16'd3, 2, $urandom);
        settle();

        set_config(7'd0, 32'h0000_0000, 12'd0, 1'b1);
        random_units(PHASE_ITEMS);
        settle();

        set_config(7'($urandom), $urandom, 12'd4095, 1'b1);
        random_units(PHASE_ITEMS);
        settle();

        set_config(7'($urandom), $urandom, 12'd3, 1'b1);
        hold_off = 1'b1;
        random_units(PHASE_ITEMS);
        settle();

        repeat (2)
        begin
            set_config(7'($urandom), $urandom, pick_max_payload(), 1'b1);
            random_units(PHASE_ITEMS);
            settle();
        end

        src_gaps = 1'b0;
        rcv_gaps = 1'b0;
        set_config(7'($urandom), $urandom, pick_max_payload(), 1'b1);
        random_units(PHASE_ITEMS);
        settle();

        if (sb.errors == 0 && sb.due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
